// File: src/lod_pkg.sv
// Shared types, sizes and threshold constants for the LOD level selector.
// No dependencies; imported by every module of the block.
`default_nettype none
package lod_pkg;

    localparam int INSTANCE_COUNT = 1024;
    localparam int IDX_W          = $clog2(INSTANCE_COUNT);
    localparam int MAX_LEVELS     = 4;
    localparam int LEVEL_W        = 2;
    localparam int COUNT_W        = 3;

    // operand and square widths of the geometry path
    localparam int OP_W   = 35;
    localparam int SQ_W   = 70;
    localparam int SUM_W  = 72;
    localparam int ROOT_W = SUM_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int THR_W     = 13;
    localparam int THR_N     = 8;
    localparam int PROD_W    = THR_W + ROOT_W;
    localparam int LHS_W     = 73;
    localparam int CMP_W     = 80;
    localparam int THR_CULL   = 6;
    localparam int THR_UNCULL = 7;

    localparam logic [ROOT_W-1:0] MIN_DIST2X = ROOT_W'(131);

    // thresholds in twentieths of a pixel: down 0..2, up 0..2, cull, uncull
    localparam logic [THR_W-1:0] THR20 [THR_N] = '{
        THR_W'(3400), THR_W'(1360), THR_W'(544),
        THR_W'(4600), THR_W'(1840), THR_W'(736),
        THR_W'(170),  THR_W'(230)
    };

    // front (4) + root (ROOT_W) + product, sum, compare (3)
    localparam int SIDE_LEN = 4 + ROOT_W + 3;

    localparam logic [2:0] CFG_CAMERA_X    = 3'd0;
    localparam logic [2:0] CFG_CAMERA_Y    = 3'd1;
    localparam logic [2:0] CFG_CAMERA_Z    = 3'd2;
    localparam logic [2:0] CFG_PROJ_FACTOR = 3'd3;
    localparam logic [2:0] CFG_SELECT_EN   = 3'd4;

    typedef struct packed {
        logic               valid;
        logic [IDX_W-1:0]   idx;
        logic [COUNT_W-1:0] count;
        logic               skinned;
        logic               enabled;
        logic               degen;
    } t_side;

    typedef struct packed {
        logic [2:0] down;
        logic [2:0] up;
        logic       cull_below;
        logic       uncull_above;
    } t_cmp;

endpackage
`default_nettype wire

// File: src/lod_front.sv
// Box extent and center offsets, squared and summed over four stages.
// Depends on lod_pkg.
`default_nettype none
module lod_front
    import lod_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic signed [31:0]  i_min [3],
    input  wire logic signed [31:0]  i_max [3],
    input  wire logic signed [31:0]  i_cam [3],
    output logic        [SUM_W-1:0]  o_r2,
    output logic        [SUM_W-1:0]  o_d2
);

    // values 0..2 extents, 3..5 doubled center offsets
    logic [OP_W-1:0] n_op [6];
    logic [OP_W-1:0] r_op [6];
    logic [33:0]     r_ll [6];
    logic [34:0]     r_lh [6];
    logic [35:0]     r_hh [6];
    logic [SQ_W-1:0] r_sq [6];
    logic [SUM_W-1:0] r_r2, r_d2;

    always_comb begin
        logic signed [OP_W-1:0] e, c;
        for (int i = 0; i < 3; i++) begin
            e = OP_W'(i_max[i]) - OP_W'(i_min[i]);
            c = OP_W'(i_max[i]) + OP_W'(i_min[i]) - (OP_W'(i_cam[i]) <<< 1);
            n_op[i]     = e[OP_W-1] ? OP_W'(-e) : OP_W'(e);
            n_op[i + 3] = c[OP_W-1] ? OP_W'(-c) : OP_W'(c);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 6; i++) begin
            r_op[i] <= n_op[i];
            r_ll[i] <= 34'(r_op[i][16:0]) * 34'(r_op[i][16:0]);
            r_lh[i] <= 35'(r_op[i][34:17]) * 35'(r_op[i][16:0]);
            r_hh[i] <= 36'(r_op[i][34:17]) * 36'(r_op[i][34:17]);
            r_sq[i] <= {r_hh[i][SQ_W-35:0], 34'b0} + SQ_W'({r_lh[i], 18'b0})
                       + SQ_W'(r_ll[i]);
        end
        r_r2 <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
        r_d2 <= SUM_W'(r_sq[3]) + SUM_W'(r_sq[4]) + SUM_W'(r_sq[5]);
    end

    assign o_r2 = r_r2;
    assign o_d2 = r_d2;

endmodule
`default_nettype wire

// File: src/lod_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on lod_pkg.
`default_nettype none
module lod_sqrt
    import lod_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic [SUM_W-1:0]  i_n,
    output logic      [ROOT_W-1:0] o_root
);

    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SUM_W-1:0]  r_n    [ROOT_W];

    for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SUM_W-1:0]  n_in;
        logic [REM_W+1:0]  rem_sh, trial;
        logic              ge;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign n_in    = i_n;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign root_in = r_root[s-1];
            assign n_in    = r_n[s-1];
        end

        assign rem_sh = {rem_in, n_in[SUM_W-1:SUM_W-2]};
        assign trial  = (REM_W+2)'({root_in, 2'b01});
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            r_root[s] <= {root_in[ROOT_W-2:0], ge};
            r_n[s]    <= {n_in[SUM_W-3:0], 2'b00};
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule
`default_nettype wire

// File: src/lod_state.sv
// Level and cull table with read-modify-write update and clearing pass.
// Depends on lod_pkg.
`default_nettype none
module lod_state
    import lod_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_side              i_item,
    input  wire t_cmp               i_cmp,
    output logic                    o_busy,
    output logic                    o_valid,
    output logic [IDX_W-1:0]        o_index,
    output logic [LEVEL_W-1:0]      o_level,
    output logic                    o_culled
);

    logic [LEVEL_W:0] mem [INSTANCE_COUNT];
    logic [LEVEL_W:0] r_rdata;
    t_side            r_cur;
    t_cmp             r_cmp;
    logic             r_wr_valid;
    logic [IDX_W-1:0] r_wr_idx;
    logic [LEVEL_W:0] r_wr_data;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_cnt;
    logic [IDX_W-1:0] n_clr_cnt;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_out_idx;
    logic [LEVEL_W:0] r_out_data;

    logic [LEVEL_W:0]   stored, n_data;
    logic               wr_en;

    always_comb begin
        logic [COUNT_W-1:0] cnt;
        logic [LEVEL_W-1:0] max_lvl, lvl;
        logic               cul;
        stored = (r_wr_valid && r_wr_idx == r_cur.idx) ? r_wr_data : r_rdata;
        cnt = r_cur.count;
        if (cnt == '0) cnt = COUNT_W'(1);
        if (cnt > COUNT_W'(MAX_LEVELS)) cnt = COUNT_W'(MAX_LEVELS);
        max_lvl = LEVEL_W'(cnt - COUNT_W'(1));
        lvl = stored[LEVEL_W-1:0];
        if (lvl > max_lvl) lvl = max_lvl;
        for (int k = 0; k < 3; k++) begin
            if (lvl < max_lvl && r_cmp.down[lvl]) lvl = lvl + LEVEL_W'(1);
        end
        for (int k = 0; k < 3; k++) begin
            if (lvl != '0 && !r_cmp.up[lvl - LEVEL_W'(1)]) lvl = lvl - LEVEL_W'(1);
        end
        cul = stored[LEVEL_W];
        if (!cul && r_cmp.cull_below) cul = 1'b1;
        else if (cul && r_cmp.uncull_above) cul = 1'b0;

        wr_en  = 1'b0;
        n_data = stored;
        if (r_cur.skinned) begin
            n_data = stored;
        end else if (!r_cur.enabled) begin
            wr_en  = 1'b1;
            n_data = '0;
        end else if (!r_cur.degen) begin
            wr_en  = 1'b1;
            n_data = {cul, lvl};
        end
        wr_en = wr_en && r_cur.valid;
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            mem[r_clr_cnt] <= '0;
        end else if (wr_en) begin
            mem[r_cur.idx] <= n_data;
        end
        r_rdata    <= mem[i_item.idx];
        r_cur      <= i_item;
        r_cmp      <= i_cmp;
        r_wr_idx   <= r_cur.idx;
        r_wr_data  <= n_data;
        r_out_idx  <= r_cur.idx;
        r_out_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_wr_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_clr_cnt   <= n_clr_cnt;
            if (r_clr_busy && r_clr_cnt == IDX_W'(INSTANCE_COUNT - 1)) r_clr_busy <= 1'b0;
            r_wr_valid  <= wr_en && !r_clr_busy;
            r_out_valid <= r_cur.valid && !r_clr_busy;
        end
    end

    assign n_clr_cnt = r_clr_busy ? r_clr_cnt + IDX_W'(1) : '0;

    assign o_busy   = r_clr_busy;
    assign o_valid  = r_out_valid;
    assign o_index  = r_out_idx;
    assign o_level  = r_out_data[LEVEL_W-1:0];
    assign o_culled = r_out_data[LEVEL_W];

    a_no_item_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_cur.valid)
        else $error("item in table stage during clearing pass");
    a_clear_ends_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> r_clr_cnt == '0)
        else $error("clearing pass ended off count");
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur.valid && !r_clr_busy |=> r_out_valid)
        else $error("result strobe missing");

endmodule
`default_nettype wire

// File: src/lod_level_select_hysteresis.sv
// Top level of the screen-space LOD selector with hysteresis.
// Depends on lod_pkg, lod_front, lod_sqrt, lod_state.
//
// Usage:
//   Items enter on start when busy is low. One instance index, a world box
//   (signed Q16.16), a level count and a skinned flag form a transaction.
//   Each item gives exactly one result, shown for one cycle with
//   o_result_valid high: index, level after update and cull flag.
//   Throughput: one item per cycle while busy is low; the root stages of
//   the distance and radius each yield one bit per stage, and the table
//   is read one stage ahead of its write, with the last write forwarded.
//   Configuration: cfg channel with valid/ready, ready always high; index
//   0..2 camera x/y/z, 3 projection factor, 4 select enable. Write only
//   while no item is in flight.
//   Reset: synchronous, active low. After reset all 1024 table entries are
//   cleared one entry per cycle with busy high; config writes are taken.
//   The receiver cannot stall: results are not held.
`default_nettype none
module lod_level_select_hysteresis
    import lod_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [IDX_W-1:0]     i_instance_index,
    input  wire logic signed [31:0]   i_box_min_x,
    input  wire logic signed [31:0]   i_box_min_y,
    input  wire logic signed [31:0]   i_box_min_z,
    input  wire logic signed [31:0]   i_box_max_x,
    input  wire logic signed [31:0]   i_box_max_y,
    input  wire logic signed [31:0]   i_box_max_z,
    input  wire logic [COUNT_W-1:0]   i_level_count,
    input  wire logic                 i_skinned,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_result_valid,
    output logic [IDX_W-1:0]          o_out_index,
    output logic [LEVEL_W-1:0]        o_lod_level,
    output logic                      o_culled
);

    logic signed [31:0] r_cam [3];
    logic [31:0]        r_proj;
    logic               r_enabled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0]  <= '0;
            r_cam[1]  <= '0;
            r_cam[2]  <= '0;
            r_proj    <= 32'd61296279;
            r_enabled <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAMERA_X:    r_cam[0]  <= i_cfg_data;
                CFG_CAMERA_Y:    r_cam[1]  <= i_cfg_data;
                CFG_CAMERA_Z:    r_cam[2]  <= i_cfg_data;
                CFG_PROJ_FACTOR: r_proj    <= i_cfg_data;
                CFG_SELECT_EN:   r_enabled <= i_cfg_data[0];
                default:         ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    logic  accept;
    t_side r_side [SIDE_LEN];
    t_side n_side;

    assign accept = start && !busy;

    always_comb begin
        n_side.valid   = accept;
        n_side.idx     = i_instance_index;
        n_side.count   = i_level_count;
        n_side.skinned = i_skinned;
        n_side.enabled = r_enabled;
        n_side.degen   = (i_box_min_x == i_box_max_x) && (i_box_min_y == i_box_max_y)
                         && (i_box_min_z == i_box_max_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SIDE_LEN; i++) r_side[i] <= '0;
        end else begin
            r_side[0] <= n_side;
            for (int i = 1; i < SIDE_LEN; i++) r_side[i] <= r_side[i-1];
        end
    end

    logic signed [31:0] box_min [3];
    logic signed [31:0] box_max [3];
    logic [SUM_W-1:0]   r2, d2;
    logic [ROOT_W-1:0]  rad2x, dist2x;

    assign box_min[0] = i_box_min_x;
    assign box_min[1] = i_box_min_y;
    assign box_min[2] = i_box_min_z;
    assign box_max[0] = i_box_max_x;
    assign box_max[1] = i_box_max_y;
    assign box_max[2] = i_box_max_z;

    lod_front u_front (
        .i_clk (i_clk),
        .i_min (box_min),
        .i_max (box_max),
        .i_cam (r_cam),
        .o_r2  (r2),
        .o_d2  (d2)
    );

    lod_sqrt u_sqrt_rad (.i_clk(i_clk), .i_n(r2), .o_root(rad2x));
    lod_sqrt u_sqrt_dist (.i_clk(i_clk), .i_n(d2), .o_root(dist2x));

    logic [ROOT_W-1:0] dist_cl;
    logic [ROOT_W+4:0] rad20;
    logic [51:0]       r_lhs_lo;
    logic [52:0]       r_lhs_hi;
    logic [PROD_W-1:0] r_thr_a [THR_N];
    logic [PROD_W-1:0] r_thr_b [THR_N];
    logic [LHS_W-1:0]  r_lhs;
    t_cmp              r_cmp;
    t_cmp              n_cmp;

    assign dist_cl = (dist2x < MIN_DIST2X) ? MIN_DIST2X : dist2x;
    assign rad20   = (ROOT_W+5)'({rad2x, 4'b0}) + (ROOT_W+5)'({rad2x, 2'b0});

    always_ff @(posedge i_clk) begin
        r_lhs_lo <= 52'(rad20[19:0]) * 52'(r_proj);
        r_lhs_hi <= 53'(rad20[ROOT_W+4:20]) * 53'(r_proj);
        for (int k = 0; k < THR_N; k++) begin
            r_thr_a[k] <= PROD_W'(THR20[k]) * PROD_W'(dist_cl);
            r_thr_b[k] <= r_thr_a[k];
        end
        r_lhs <= LHS_W'({r_lhs_hi, 20'b0}) + LHS_W'(r_lhs_lo);
        r_cmp <= n_cmp;
    end

    always_comb begin
        logic [CMP_W-1:0] lhs_x;
        logic [CMP_W-1:0] thr_x [THR_N];
        lhs_x = CMP_W'(r_lhs);
        for (int k = 0; k < THR_N; k++) thr_x[k] = CMP_W'({r_thr_b[k], 16'b0});
        for (int k = 0; k < 3; k++) begin
            n_cmp.down[k] = lhs_x < thr_x[k];
            n_cmp.up[k]   = lhs_x < thr_x[k + 3];
        end
        n_cmp.cull_below   = lhs_x < thr_x[THR_CULL];
        n_cmp.uncull_above = lhs_x > thr_x[THR_UNCULL];
    end

    lod_state u_state (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (r_side[SIDE_LEN-1]),
        .i_cmp    (r_cmp),
        .o_busy   (busy),
        .o_valid  (o_result_valid),
        .o_index  (o_out_index),
        .o_level  (o_lod_level),
        .o_culled (o_culled)
    );

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for lod_level_select_hysteresis: random and directed instances, with scoreboard.
// Depends on lod_pkg and the block; the expected levels come from a behavioral predictor.
`timescale 1ns / 100ps
module tb;
    import lod_pkg::*;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic signed [31:0] mn [3];
        logic signed [31:0] mx [3];
        logic [COUNT_W-1:0] count;
        logic               skinned;
    } t_inst;

    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [LEVEL_W-1:0] lvl;
        logic               cul;
    } t_lod;

    logic i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic [IDX_W-1:0] i_instance_index = '0;
    logic signed [31:0] i_box_min_x = 0, i_box_min_y = 0, i_box_min_z = 0;
    logic signed [31:0] i_box_max_x = 0, i_box_max_y = 0, i_box_max_z = 0;
    logic [COUNT_W-1:0] i_level_count = '0;
    logic i_skinned = 0, i_cfg_valid = 0, o_cfg_ready;
    logic [2:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_result_valid, o_culled;
    logic [IDX_W-1:0] o_out_index;
    logic [LEVEL_W-1:0] o_lod_level;

    lod_level_select_hysteresis DUT (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // predictor state
    logic signed [31:0] cam [3];
    logic [31:0] proj;
    logic sel_en;
    logic [1:0] lvl_mem [INSTANCE_COUNT];
    logic cul_mem [INSTANCE_COUNT];

    t_inst pending_q[$];
    t_lod  expected_q[$];
    int errors = 0, n_results = 0, sender_idle = 0;
    int n_culled = 0, n_lvl3 = 0;

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0] r, c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] absdiff(logic signed [63:0] v);
        return v < 0 ? -v : v;
    endfunction

    function automatic logic lt_thr(logic [127:0] lhs, logic [63:0] t20, logic [63:0] d);
        return lhs < ({64'd0, t20 << 16} * {64'd0, d});
    endfunction

    function automatic t_lod select_lod(t_inst it);
        t_lod r;
        logic [63:0] ext [3], ctr [3], rad, dd, maxl, lvl;
        logic [127:0] r2, d2, lhs;
        logic [63:0] dn [3], up [3];
        logic c;
        dn = '{3400, 1360, 544};
        up = '{4600, 1840, 736};
        r.idx = it.idx;
        r.lvl = lvl_mem[it.idx];
        r.cul = cul_mem[it.idx];
        if (it.skinned) return r;
        if (!sel_en) begin
            lvl_mem[it.idx] = 0;
            cul_mem[it.idx] = 0;
            r.lvl = 0;
            r.cul = 0;
            return r;
        end
        r2 = 0;
        d2 = 0;
        for (int i = 0; i < 3; i++) begin
            ext[i] = absdiff(64'(it.mx[i]) - 64'(it.mn[i]));
            ctr[i] = absdiff(64'(it.mn[i]) + 64'(it.mx[i]) - 2 * 64'(cam[i]));
            r2 += {64'd0, ext[i]} * {64'd0, ext[i]};
            d2 += {64'd0, ctr[i]} * {64'd0, ctr[i]};
        end
        if (r2 == 0) return r;
        rad = isqrt(r2);
        dd = isqrt(d2);
        if (dd < 131) dd = 131;
        lhs = {64'd0, rad * 20} * {96'd0, proj};
        maxl = (it.count == 0) ? 0 : (it.count > 4 ? 3 : it.count - 1);
        lvl = lvl_mem[it.idx];
        if (lvl > maxl) lvl = maxl;
        while (lvl < maxl && lt_thr(lhs, dn[lvl], dd)) lvl++;
        while (lvl > 0 && !lt_thr(lhs, up[lvl-1], dd)) lvl--;
        c = cul_mem[it.idx];
        if (!c && lt_thr(lhs, 170, dd)) c = 1;
        else if (c && lhs > ({64'd0, 64'd230 << 16} * {64'd0, dd})) c = 0;
        lvl_mem[it.idx] = lvl[1:0];
        cul_mem[it.idx] = c;
        r.lvl = lvl[1:0];
        r.cul = c;
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_lod pred;
        if (i_rst_n && !(start && busy)) begin
            if (start && !busy) begin
                pred = select_lod(pending_q.pop_front());
                expected_q = {expected_q, pred};
            end
            if (pending_q.size() > 0 && $urandom_range(99) >= sender_idle) begin
                start <= 1;
                i_instance_index <= pending_q[0].idx;
                i_box_min_x <= pending_q[0].mn[0];
                i_box_min_y <= pending_q[0].mn[1];
                i_box_min_z <= pending_q[0].mn[2];
                i_box_max_x <= pending_q[0].mx[0];
                i_box_max_y <= pending_q[0].mx[1];
                i_box_max_z <= pending_q[0].mx[2];
                i_level_count <= pending_q[0].count;
                i_skinned <= pending_q[0].skinned;
            end else begin
                start <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_lod e;
        if (i_rst_n && o_result_valid) begin
            n_results++;
            if (expected_q.size() == 0) begin
                $error("unexpected transaction index %0d", o_out_index);
                errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_out_index !== e.idx) begin
                    $error("out_index exp %0d got %0d", e.idx, o_out_index);
                    errors++;
                end
                if (o_lod_level !== e.lvl) begin
                    $error("lod_level exp %0d got %0d", e.lvl, o_lod_level);
                    errors++;
                end
                if (o_culled !== e.cul) begin
                    $error("culled exp %0d got %0d", e.cul, o_culled);
                    errors++;
                end
                if (e.cul) n_culled++;
                if (e.lvl == 3) n_lvl3++;
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        case (idx)
            CFG_CAMERA_X:    cam[0] = data;
            CFG_CAMERA_Y:    cam[1] = data;
            CFG_CAMERA_Z:    cam[2] = data;
            CFG_PROJ_FACTOR: proj = data;
            CFG_SELECT_EN:   sel_en = data[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || start || expected_q.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom();
            1: return $urandom_range(20000) << 8;
            default: return 32'($signed($urandom_range(400000)) - 200000) <<< 4;
        endcase
    endfunction

    task automatic add_inst(logic [IDX_W-1:0] idx, logic signed [31:0] c, logic [31:0] half,
                            logic [COUNT_W-1:0] cnt, logic sk);
        t_inst it;
        it.idx = idx;
        for (int i = 0; i < 3; i++) begin
            it.mn[i] = c - half;
            it.mx[i] = c + half;
        end
        it.count = cnt;
        it.skinned = sk;
        pending_q = {pending_q, it};
    endtask

    task automatic add_random(int n, int pool);
        t_inst it;
        logic signed [31:0] c;
        logic [31:0] half;
        for (int k = 0; k < n; k++) begin
            it.idx = (pool > 0) ? IDX_W'($urandom_range(pool - 1))
                                : IDX_W'($urandom_range(1023));
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(9) == 0) begin
                    it.mn[i] = $urandom();
                    it.mx[i] = $urandom();
                end else begin
                    c = rnd_coord();
                    half = $urandom_range(1 << ($urandom_range(26)));
                    it.mn[i] = c - half;
                    it.mx[i] = c + half;
                end
            end
            if ($urandom_range(30) == 0) it.mx = it.mn;
            it.count = COUNT_W'($urandom_range(7));
            it.skinned = ($urandom_range(9) == 0);
            pending_q = {pending_q, it};
        end
    endtask

    initial begin
        cam = '{0, 0, 0};
        proj = 61296279;
        sel_en = 1;
        for (int i = 0; i < INSTANCE_COUNT; i++) begin
            lvl_mem[i] = 0;
            cul_mem[i] = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        cfg_write(CFG_CAMERA_X, 0);
        cfg_write(CFG_CAMERA_Y, 0);
        cfg_write(CFG_CAMERA_Z, 32'h0001_0000);
        cfg_write(CFG_PROJ_FACTOR, 61296279);
        cfg_write(CFG_SELECT_EN, 1);
        cfg_write(3'd7, 32'hFFFF_FFFF);

        // directed: near, far, hysteresis walk, degenerate, skinned, extremes
        add_inst(0, 32'h0010_0000, 32'h0001_0000, 4, 0);
        add_inst(0, 32'h0800_0000, 32'h0001_0000, 4, 0);
        add_inst(0, 32'h0100_0000, 32'h0001_0000, 4, 0);
        add_inst(0, 32'h0040_0000, 32'h0001_0000, 4, 0);
        add_inst(0, 32'h0040_0000, 32'h0001_0000, 4, 1);
        add_inst(0, 32'h0040_0000, 32'h0000_0000, 4, 0);
        add_inst(0, 32'h0800_0000, 32'h0001_0000, 2, 0);
        add_inst(1, 32'h0001_0000, 32'h0000_0001, 0, 0);
        add_inst(1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 7, 0);
        add_inst(1022, 32'h8000_0000, 32'h7FFF_FFFF, 5, 0);
        add_inst(512, 32'h0000_0000, 32'h8000_0000, 3, 0);
        add_inst(2, 32'h0000_0000, 32'h4000_0000, 1, 0);
        add_inst(3, 32'h2000_0000, 32'h0000_8000, 4, 0);
        add_inst(3, 32'h0200_0000, 32'h0000_8000, 4, 0);
        add_inst(3, 32'h0040_0000, 32'h0000_8000, 4, 0);
        drain();

        cfg_write(CFG_PROJ_FACTOR, 0);
        add_inst(4, 32'h0001_0000, 32'h0001_0000, 4, 0);
        drain();
        cfg_write(CFG_PROJ_FACTOR, 32'hFFFF_FFFF);
        cfg_write(CFG_CAMERA_X, 32'h8000_0000);
        cfg_write(CFG_CAMERA_Y, 32'h7FFF_FFFF);
        add_inst(4, 32'h0001_0000, 32'h0001_0000, 4, 0);
        add_random(30, 16);
        drain();
        cfg_write(CFG_SELECT_EN, 0);
        add_inst(0, 32'h0010_0000, 32'h0001_0000, 4, 0);
        add_random(30, 16);
        drain();

        // random phases
        cfg_write(CFG_SELECT_EN, 1);
        cfg_write(CFG_CAMERA_X, 0);
        cfg_write(CFG_CAMERA_Y, 0);
        cfg_write(CFG_CAMERA_Z, 0);
        cfg_write(CFG_PROJ_FACTOR, 61296279);
        sender_idle = 33;
        add_random(250, 32);
        drain();
        cfg_write(CFG_CAMERA_X, rnd_coord());
        cfg_write(CFG_CAMERA_Y, rnd_coord());
        cfg_write(CFG_CAMERA_Z, rnd_coord());
        cfg_write(CFG_PROJ_FACTOR, $urandom_range(32'h1000_0000));
        sender_idle = 87;
        add_random(200, 64);
        drain();
        cfg_write(CFG_PROJ_FACTOR, $urandom());
        sender_idle = 0;
        add_random(250, 0);
        drain();

        $display("Ran %0d transactions over several camera and projection settings;",
                 n_results);
        $display("%0d came back culled and %0d at the coarsest level.", n_culled, n_lvl3);
        if (errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
